[sv/cbc_mac_feistel16_top_defines.svh]
// ----------------------------------------------------------------------------
// CBC-MAC Feistel16 assertion macros
// Shared concurrent assertion forms, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CBC_MAC_FEISTEL16_TOP_DEFINES_SVH
`define CBC_MAC_FEISTEL16_TOP_DEFINES_SVH

// same-cycle implication
`define CMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/cmf_pkg.sv]
// ----------------------------------------------------------------------------
// CBC-MAC Feistel16 package
// Register indexes, round count reset value, config bundle type and the 4-bit S-box.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmf_pkg;

  localparam int KEY_REGS = 4;

  localparam logic [2:0] CFG_ROUND_COUNT = 3'd0;
  localparam logic [2:0] CFG_ROUND_KEY_0 = 3'd1;
  localparam logic [2:0] CFG_ROUND_KEY_1 = 3'd2;
  localparam logic [2:0] CFG_ROUND_KEY_2 = 3'd3;
  localparam logic [2:0] CFG_ROUND_KEY_3 = 3'd4;

  localparam logic [2:0] ROUND_COUNT_RESET = 3'd4;

  localparam logic [3:0] SBOX [16] = '{
    4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
    4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
  };

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [2:0]                  round_count;
    logic [KEY_REGS-1:0][7:0]    round_key;
  } cmf_cfg_t;

  function automatic logic [3:0] sbox4(input logic [3:0] x);
    return SBOX[x];
  endfunction

endpackage

[sv/cbc_mac_feistel16_top.sv]
// From input request accept to out_tvalid of its tag, a block passes the input
// register, then the tag register.
// Throughput: one block per cycle unless a last block is held by a waiting tag;
// the chaining value is encrypted combinationally by the unrolled round chain.
// A tag waiting at the output stalls only a last block behind it.
// Reset (rst_n low, synchronous): empties both stages, clears the chaining
// value, and sets round_count to 4 and all round keys to 0.
// ----------------------------------------------------------------------------
// CBC-MAC Feistel16 top
// Input register, combinational chained Feistel encrypt, tag output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cbc_mac_feistel16_top_defines.svh"

module cbc_mac_feistel16_top #(
  parameter int MAX_ROUNDS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] message_block
  input  logic        in_tlast,   // last_block
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] mac_tag
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cmf_pkg::cmf_cfg_t cfg_r;
  logic        in_valid_r;
  logic [15:0] blk_r;
  logic        last_r;
  logic [15:0] chain_r;
  logic [15:0] chain_nxt;
  logic        out_valid_r;
  logic [15:0] tag_r;
  logic        fire;
  logic [15:0] enc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.round_count <= cmf_pkg::ROUND_COUNT_RESET;
      cfg_r.round_key   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cmf_pkg::CFG_ROUND_COUNT: cfg_r.round_count  <= cfg_data[2:0];
        cmf_pkg::CFG_ROUND_KEY_0: cfg_r.round_key[0] <= cfg_data;
        cmf_pkg::CFG_ROUND_KEY_1: cfg_r.round_key[1] <= cfg_data;
        cmf_pkg::CFG_ROUND_KEY_2: cfg_r.round_key[2] <= cfg_data;
        cmf_pkg::CFG_ROUND_KEY_3: cfg_r.round_key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // a last block needs a free output slot
  assign fire      = in_valid_r && (!last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      blk_r  <= in_tdata;
      last_r <= in_tlast;
    end
  end

  cmf_cipher #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_cipher (
    .cfg  (cfg_r),
    .din  (chain_r ^ blk_r),
    .dout (enc)
  );

  always_comb begin
    chain_nxt = chain_r;
    if (fire) begin
      chain_nxt = last_r ? 16'h0000 : enc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else begin
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && last_r) begin
      tag_r <= enc;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tag_r;

  `CMF_ASSERT_NOW(a_ready_when_out_free, !out_valid_r, in_tready,
                  "input stalled with free output")
  `CMF_ASSERT_NEXT(a_chain_cleared, fire && last_r, chain_r == 16'h0000,
                   "chain not cleared after tag")
  `CMF_ASSERT_NEXT(a_hold_stalled, in_valid_r && !fire,
                   in_valid_r && $stable(blk_r) && $stable(last_r), "stalled block lost")
  `CMF_ASSERT_NEXT(a_zero_rounds, fire && !last_r && cfg_r.round_count == 3'd0,
                   chain_r == $past(chain_r ^ blk_r), "zero rounds not pass-through")

endmodule

[sv/cmf_round.sv]
// ----------------------------------------------------------------------------
// CBC-MAC Feistel16 round
// One Feistel round on 8-bit halves; passes the halves through when disabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmf_round (
  input  logic          en,
  input  cmf_pkg::byte_t key,
  input  cmf_pkg::byte_t l_in,
  input  cmf_pkg::byte_t r_in,
  output cmf_pkg::byte_t l_out,
  output cmf_pkg::byte_t r_out
);

  cmf_pkg::byte_t x;
  cmf_pkg::byte_t f;

  assign x = r_in ^ key;
  assign f = {cmf_pkg::sbox4(x[7:4]), cmf_pkg::sbox4(x[3:0])};

  assign l_out = en ? r_in : l_in;
  assign r_out = en ? (l_in ^ f) : r_in;

endmodule

[sv/cmf_cipher.sv]
// ----------------------------------------------------------------------------
// CBC-MAC Feistel16 cipher
// Chain of Feistel rounds; rounds past the saturated round count pass through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmf_cipher #(
  parameter int MAX_ROUNDS = 4
) (
  input  cmf_pkg::cmf_cfg_t cfg,
  input  logic [15:0]       din,
  output logic [15:0]       dout
);

  logic [2:0] n_rounds;
  cmf_pkg::byte_t l_w [MAX_ROUNDS+1];
  cmf_pkg::byte_t r_w [MAX_ROUNDS+1];

  always_comb begin
    if (cfg.round_count > 3'(MAX_ROUNDS)) begin
      n_rounds = 3'(MAX_ROUNDS);
    end else begin
      n_rounds = cfg.round_count;
    end
  end

  assign l_w[0] = din[15:8];
  assign r_w[0] = din[7:0];

  for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_round
    cmf_round u_round (
      .en    (3'(i) < n_rounds),
      .key   (cfg.round_key[i % cmf_pkg::KEY_REGS]),
      .l_in  (l_w[i]),
      .r_in  (r_w[i]),
      .l_out (l_w[i+1]),
      .r_out (r_w[i+1])
    );
  end

  assign dout = {l_w[MAX_ROUNDS], r_w[MAX_ROUNDS]};

endmodule

[tb/cbc_mac_feistel16_top_tb.sv]
// ----------------------------------------------------------------------------
// CBC-MAC Feistel16 testbench
// Streams message blocks into the MAC engine under several round counts and
// key sets, and predicts every tag with an independent Feistel model. Tags are
// compared in order as they leave the block. Random sender gaps and receiver
// stalls are applied, plus one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbc_mac_feistel16_top_tb;

  localparam int MAX_ROUNDS    = 4;
  localparam int MAX_ERR_SHOWN = 10;
  localparam int SETTLE_CYCLES = 4;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  // mirror of the MAC engine state
  logic [2:0]      round_cnt;
  cmf_pkg::byte_t  round_key [cmf_pkg::KEY_REGS];
  logic [15:0]     chain_val;
  logic [15:0]     expected_tags [$];
  logic [15:0]     exp_tag;

  int blocks_sent;
  int tags_seen;
  int cfg_writes;
  int err_cnt;
  int burst_left;
  int max_gap;
  int stall_mode;
  int hold_req;

  cbc_mac_feistel16_top #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** cbc_mac_feistel16_top: FAILED **");
    $finish;
  end

  function automatic logic [15:0] model_cipher16(input logic [15:0] v);
    cmf_pkg::byte_t l, r, x, f, t;
    int    n;
    l = v[15:8];
    r = v[7:0];
    n = (round_cnt > MAX_ROUNDS) ? MAX_ROUNDS : round_cnt;
    for (int i = 0; i < n; i++) begin
      x = r ^ round_key[i % cmf_pkg::KEY_REGS];
      f = {cmf_pkg::SBOX[x[7:4]], cmf_pkg::SBOX[x[3:0]]};
      t = l ^ f;
      l = r;
      r = t;
    end
    return {l, r};
  endfunction

  // one block request; bursts of random length with random gaps between
  task automatic send_block(input logic [15:0] blk, input logic last_b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= blk;
    in_tlast  <= last_b;
    do @(posedge clk); while (!in_tready);
    blocks_sent++;
    chain_val = model_cipher16(chain_val ^ blk);
    if (last_b) begin
      expected_tags.push_back(chain_val);
      chain_val = '0;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input cmf_pkg::byte_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      cmf_pkg::CFG_ROUND_COUNT: round_cnt = data[2:0];
      cmf_pkg::CFG_ROUND_KEY_0, cmf_pkg::CFG_ROUND_KEY_1,
      cmf_pkg::CFG_ROUND_KEY_2, cmf_pkg::CFG_ROUND_KEY_3:
        round_key[2'(idx - cmf_pkg::CFG_ROUND_KEY_0)] = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_keys(input cmf_pkg::byte_t k0, input cmf_pkg::byte_t k1,
                            input cmf_pkg::byte_t k2, input cmf_pkg::byte_t k3);
    write_reg(cmf_pkg::CFG_ROUND_KEY_0, k0);
    write_reg(cmf_pkg::CFG_ROUND_KEY_1, k1);
    write_reg(cmf_pkg::CFG_ROUND_KEY_2, k2);
    write_reg(cmf_pkg::CFG_ROUND_KEY_3, k3);
  endtask

  // stop sending, let every tag out, then cover the pipeline of non-last blocks
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_block();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cmf_pkg::byte_t rand_key();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_block(rand_block(), i == len - 1);
  endtask

  task automatic test_reset_defaults();
    send_block(16'h0000, 1'b1);
    send_block(16'hFFFF, 1'b1);
    send_block(16'h8000, 1'b1);
    send_block(16'h0001, 1'b1);
    send_block(16'h1234, 1'b0);
    send_block(16'hABCD, 1'b0);
    send_block(16'hFFFF, 1'b1);
    drain();
  endtask

  // every round count, including the saturated ones above the limit
  task automatic test_round_counts();
    write_keys(8'hFF, 8'h00, 8'hA5, 8'h5A);
    for (int rc = 0; rc < 8; rc++) begin
      write_reg(cmf_pkg::CFG_ROUND_COUNT, cmf_pkg::byte_t'(rc));
      send_block(16'hFFFF, 1'b0);
      send_block(16'h0000, 1'b1);
      drain();
    end
  endtask

  // unused indexes must not disturb anything; key change mid-message
  task automatic test_unused_index();
    write_reg(cmf_pkg::CFG_ROUND_COUNT, cmf_pkg::byte_t'(MAX_ROUNDS));
    send_block(16'h5A5A, 1'b0);
    drain();
    for (int i = cmf_pkg::CFG_ROUND_KEY_3 + 1; i < 8; i++) write_reg(3'(i), 8'hFF);
    write_reg(cmf_pkg::CFG_ROUND_KEY_0, 8'h3C);
    send_block(16'hC3C3, 1'b1);
    drain();
  endtask

  task automatic test_random_messages();
    int start;
    int len;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0:       write_reg(cmf_pkg::CFG_ROUND_COUNT, 8'd0);
        1:       write_reg(cmf_pkg::CFG_ROUND_COUNT, 8'd7);
        2:       write_reg(cmf_pkg::CFG_ROUND_COUNT, cmf_pkg::byte_t'(MAX_ROUNDS));
        default: write_reg(cmf_pkg::CFG_ROUND_COUNT,
                           cmf_pkg::byte_t'($urandom_range(0, 7)));
      endcase
      write_keys(rand_key(), rand_key(), rand_key(), rand_key());
      if ($urandom_range(0, 2) == 0)
        write_reg(3'($urandom_range(cmf_pkg::CFG_ROUND_KEY_3 + 1, 7)), 8'($urandom));
      stall_mode = phase % 4;
      max_gap    = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 3 : 10;
      start      = blocks_sent;
      while (blocks_sent - start < 155) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
        send_message(len);
      end
      drain();
    end
  endtask

  // long output hold-off while single-block messages keep coming
  task automatic test_backpressure();
    stall_mode = 0;
    max_gap    = 0;
    hold_req   = 80;
    for (int i = 0; i < 40; i++) send_block(rand_block(), 1'b1);
    drain();
  endtask

  initial begin
    int hold_left;
    int tick;
    hold_left = 0;
    tick      = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= (tick % 4 == 0);
          default: out_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tags.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_ERR_SHOWN)
          $display("ERROR %0t: unexpected tag %h", $realtime, out_tdata);
      end else begin
        exp_tag = expected_tags.pop_front();
        tags_seen++;
        if (out_tdata !== exp_tag) begin
          err_cnt++;
          if (err_cnt <= MAX_ERR_SHOWN)
            $display("ERROR %0t: mac_tag expected %h actual %h", $realtime, exp_tag,
                     out_tdata);
        end
      end
    end
  end

  initial begin
    blocks_sent = 0;
    tags_seen   = 0;
    cfg_writes  = 0;
    err_cnt     = 0;
    burst_left  = 0;
    max_gap     = 0;
    stall_mode  = 0;
    hold_req    = 0;
    round_cnt   = cmf_pkg::ROUND_COUNT_RESET;
    chain_val   = '0;
    for (int i = 0; i < cmf_pkg::KEY_REGS; i++) round_key[i] = '0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_round_counts();
    test_unused_index();
    test_backpressure();
    test_random_messages();

    drain();
    repeat (10) @(posedge clk);
    if (expected_tags.size() != 0) begin
      err_cnt++;
      $display("ERROR: %0d tags never arrived", expected_tags.size());
    end
    $display("Run: %0d blocks sent, %0d tags checked, %0d register writes, %0d errors",
             blocks_sent, tags_seen, cfg_writes, err_cnt);
    $display("Covered round counts 0-7 with saturation, unused indexes, stalls, hold-off");
    if (err_cnt == 0) begin
      $display("** cbc_mac_feistel16_top: PASSED **");
    end else begin
      $display("** cbc_mac_feistel16_top: FAILED **");
    end
    $finish;
  end

endmodule
